/* src/twd_pkg.sv */
package twd_pkg;

  // Fixed field widths of the request and response words
  localparam int CMD_W   = 2;
  localparam int TABLE_W = 6;
  localparam int TXN_W   = 16;
  localparam int STAMP_W = 32;
  localparam int STAT_W  = 3;
  localparam int MODE_W  = 2;

  // Request commands; any code at or above unlock releases
  localparam logic [CMD_W-1:0] CMD_LOCK_S = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOCK_X = 2'd1;
  localparam logic [CMD_W-1:0] CMD_UNLOCK = 2'd2;

  typedef enum logic [STAT_W-1:0] {
    STAT_GRANTED      = 3'd0,
    STAT_HELD         = 3'd1,
    STAT_UPGRADED     = 3'd2,
    STAT_WAIT         = 3'd3,
    STAT_ABORT_SHRINK = 3'd4,
    STAT_ABORT_DIE    = 3'd5,
    STAT_RELEASED     = 3'd6,
    STAT_FULL         = 3'd7
  } status_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_NONE = 2'd0,
    MODE_S    = 2'd1,
    MODE_X    = 2'd2
  } mode_t;

endpackage

/* src/twd_if.sv */
// Request channel
interface twd_req_if;
  logic                           valid;
  logic                           ready;
  logic [twd_pkg::CMD_W-1:0]      command;
  logic [twd_pkg::TABLE_W-1:0]    table_id;
  logic [twd_pkg::TXN_W-1:0]      txn_id;
  logic [twd_pkg::STAMP_W-1:0]    start_stamp;
  logic                           txn_shrinking;

  modport source(output valid, command, table_id, txn_id, start_stamp, txn_shrinking,
                 input ready);
  modport sink(input valid, command, table_id, txn_id, start_stamp, txn_shrinking,
               output ready);
endinterface

// Response channel
interface twd_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [twd_pkg::STAT_W-1:0]  status;
  logic [twd_pkg::MODE_W-1:0]  group_mode;

  modport source(output valid, status, group_mode, input ready);
  modport sink(input valid, status, group_mode, output ready);
endinterface

/* src/twd_ram.sv */
// Simple dual-port RAM: one write port, one read port, registered read data
module twd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* src/table_lock_wait_die.sv */
// Table-level shared/exclusive lock manager with wait-die deadlock prevention.
//
// in_req carries one request word (lock shared, lock exclusive or unlock) for one
// table on behalf of one transaction; out_rsp returns one word per request with
// the status and the table's group mode afterwards. Both are valid/ready channels.
//
// Each request walks the HOLDERS slots of its table through the holder RAM read
// port, one slot per cycle; a drain state lets the last read return, and a
// decide state decides and writes back. A new request is taken only once the
// current one has left the decide step and the block is back in idle.
//
// After reset the block clears all TABLES*HOLDERS holder RAM entries (1024 by
// default), one entry per cycle; in_req.ready stays low meanwhile.
// The response sits in an output register: a request may be taken while a word
// waits there, but the decision step holds until out_rsp.ready frees it.
module table_lock_wait_die #(
  parameter int TABLES   = 64,
  parameter int HOLDERS  = 16,
  parameter int TXN_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  twd_req_if.sink   in_req,
  twd_rsp_if.source out_rsp
);

  localparam int DEPTH = TABLES * HOLDERS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int HW    = (HOLDERS > 1) ? $clog2(HOLDERS) : 1;
  localparam int SW    = 2 + twd_pkg::STAMP_W + TXN_BITS;
  localparam int NIDS  = 2 ** twd_pkg::TABLE_W;

  // Slot word layout: {valid, excl, stamp, txn}
  localparam int TXN_LO = 0;
  localparam int STP_LO = TXN_BITS;
  localparam int EXC_B  = TXN_BITS + twd_pkg::STAMP_W;
  localparam int VLD_B  = EXC_B + 1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DECIDE
  } state_t;

  state_t state_r, state_nxt;

  // Row base address per table id, with wrap modulo TABLES
  logic [AW-1:0] base_lut [NIDS];
  for (genvar g = 0; g < NIDS; g++) begin : g_base
    assign base_lut[g] = AW'((g % TABLES) * HOLDERS);
  end

  // Request registers
  logic [twd_pkg::CMD_W-1:0]   cmd_r;
  logic [TXN_BITS-1:0]         key_r;
  logic [twd_pkg::STAMP_W-1:0] stamp_r;
  logic                        shrink_r;
  logic [AW-1:0]               base_r;

  // Scan bookkeeping
  logic [HW-1:0] idx_r, idx_nxt;
  logic          pend_r, pend_nxt;
  logic [HW-1:0] pend_idx_r;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;

  // Accumulated row summary
  logic                        found_r, found_excl_r;
  logic [HW-1:0]               found_idx_r;
  logic [twd_pkg::STAMP_W-1:0] found_stamp_r;
  logic                        free_ok_r;
  logic [HW-1:0]               free_idx_r;
  logic                        cur_any_r, cur_x_r, oth_any_r, oth_x_r, oth_old_r;

  // Output register
  logic                      out_valid_r, out_valid_nxt;
  twd_pkg::status_t          out_status_r, out_status_nxt;
  twd_pkg::mode_t            out_mode_r, out_mode_nxt;

  // RAM ports
  logic          ram_wr_en, ram_rd_en;
  logic [AW-1:0] ram_wr_addr, ram_rd_addr;
  logic [SW-1:0] ram_wr_data, ram_rd_data;

  twd_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_slots (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  logic in_fire, out_free;
  assign in_req.ready = (state_r == S_IDLE);
  assign in_fire      = in_req.valid && in_req.ready;
  assign out_free     = !out_valid_r || out_rsp.ready;

  assign out_rsp.valid      = out_valid_r;
  assign out_rsp.status     = out_status_r;
  assign out_rsp.group_mode = out_mode_r;

  // Compare unit on the slot word returned by the RAM
  logic                        s_vld, s_exc, s_match, s_other, s_not_younger;
  logic [twd_pkg::STAMP_W-1:0] s_stamp;
  logic                        is_unlock, want_x;

  always_comb begin
    s_vld         = ram_rd_data[VLD_B];
    s_exc         = ram_rd_data[EXC_B];
    s_stamp       = ram_rd_data[STP_LO +: twd_pkg::STAMP_W];
    s_match       = s_vld && (ram_rd_data[TXN_LO +: TXN_BITS] == key_r);
    s_other       = s_vld && !s_match;
    s_not_younger = !(stamp_r < s_stamp);
  end

  assign is_unlock = (cmd_r >= twd_pkg::CMD_UNLOCK);
  assign want_x    = (cmd_r == twd_pkg::CMD_LOCK_X);

  // Decision on the finished row summary
  twd_pkg::status_t dec_status;
  twd_pkg::mode_t   dec_mode, cur_mode, oth_mode;
  logic             dec_wr;
  logic [HW-1:0]    dec_idx;
  logic             dec_excl;
  logic [twd_pkg::STAMP_W-1:0] dec_stamp;

  always_comb begin
    cur_mode = cur_x_r ? twd_pkg::MODE_X : (cur_any_r ? twd_pkg::MODE_S : twd_pkg::MODE_NONE);
    oth_mode = oth_x_r ? twd_pkg::MODE_X : (oth_any_r ? twd_pkg::MODE_S : twd_pkg::MODE_NONE);
    dec_status = twd_pkg::STAT_HELD;
    dec_mode   = cur_mode;
    dec_wr     = 1'b0;
    dec_idx    = free_idx_r;
    dec_excl   = want_x;
    dec_stamp  = stamp_r;
    if (is_unlock) begin
      dec_status = twd_pkg::STAT_RELEASED;
      dec_mode   = oth_mode;
    end else if (shrink_r) begin
      dec_status = twd_pkg::STAT_ABORT_SHRINK;
    end else if (found_r) begin
      if (!want_x || found_excl_r) begin
        dec_status = twd_pkg::STAT_HELD;
      end else if (!oth_any_r) begin
        // lone shared holder becomes exclusive in place
        dec_status = twd_pkg::STAT_UPGRADED;
        dec_mode   = twd_pkg::MODE_X;
        dec_wr     = 1'b1;
        dec_idx    = found_idx_r;
        dec_excl   = 1'b1;
        dec_stamp  = found_stamp_r;
      end else begin
        dec_status = twd_pkg::STAT_ABORT_DIE;
      end
    end else if ((want_x && cur_any_r) || (!want_x && cur_x_r)) begin
      // wait only if strictly older than every other holder
      dec_status = oth_old_r ? twd_pkg::STAT_ABORT_DIE : twd_pkg::STAT_WAIT;
    end else if (!free_ok_r) begin
      dec_status = twd_pkg::STAT_FULL;
    end else begin
      dec_status = twd_pkg::STAT_GRANTED;
      dec_mode   = want_x ? twd_pkg::MODE_X : twd_pkg::MODE_S;
      dec_wr     = 1'b1;
    end
  end

  // Sequencer next state and RAM port control
  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    pend_nxt       = 1'b0;
    clr_addr_nxt   = clr_addr_r;
    out_valid_nxt  = out_valid_r && !out_rsp.ready;
    out_status_nxt = out_status_r;
    out_mode_nxt   = out_mode_r;
    ram_rd_en      = 1'b0;
    ram_rd_addr    = base_r + AW'(idx_r);
    ram_wr_en      = 1'b0;
    ram_wr_addr    = base_r + AW'(pend_idx_r);
    ram_wr_data    = '0;

    // unlock drops each matching slot as it comes back from the RAM
    if (pend_r && is_unlock && s_match) begin
      ram_wr_en = 1'b1;
    end

    case (state_r)
      S_CLEAR: begin
        ram_wr_en    = 1'b1;
        ram_wr_addr  = clr_addr_r;
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        idx_nxt = '0;
        if (in_fire) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        ram_rd_en = 1'b1;
        pend_nxt  = 1'b1;
        idx_nxt   = idx_r + HW'(1);
        if (idx_r == HW'(HOLDERS - 1)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = dec_status;
          out_mode_nxt   = dec_mode;
          ram_wr_en      = dec_wr;
          ram_wr_addr    = base_r + AW'(dec_idx);
          ram_wr_data    = {1'b1, dec_excl, dec_stamp, key_r};
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_addr_r   <= '0;
      pend_r       <= 1'b0;
      idx_r        <= '0;
      out_valid_r  <= 1'b0;
      out_status_r <= twd_pkg::STAT_GRANTED;
      out_mode_r   <= twd_pkg::MODE_NONE;
    end else begin
      state_r      <= state_nxt;
      clr_addr_r   <= clr_addr_nxt;
      pend_r       <= pend_nxt;
      idx_r        <= idx_nxt;
      out_valid_r  <= out_valid_nxt;
      out_status_r <= out_status_nxt;
      out_mode_r   <= out_mode_nxt;
    end
  end

  // Request capture and row summary
  always_ff @(posedge clk) begin
    pend_idx_r <= idx_r;
    if (in_fire) begin
      cmd_r     <= in_req.command;
      key_r     <= TXN_BITS'(in_req.txn_id);
      stamp_r   <= in_req.start_stamp;
      shrink_r  <= in_req.txn_shrinking;
      base_r    <= base_lut[in_req.table_id];
      found_r   <= 1'b0;
      free_ok_r <= 1'b0;
      cur_any_r <= 1'b0;
      cur_x_r   <= 1'b0;
      oth_any_r <= 1'b0;
      oth_x_r   <= 1'b0;
      oth_old_r <= 1'b0;
    end else if (pend_r) begin
      if (s_match && !found_r) begin
        found_r       <= 1'b1;
        found_idx_r   <= pend_idx_r;
        found_excl_r  <= s_exc;
        found_stamp_r <= s_stamp;
      end
      if (!s_vld && !free_ok_r) begin
        free_ok_r  <= 1'b1;
        free_idx_r <= pend_idx_r;
      end
      cur_any_r <= cur_any_r || s_vld;
      cur_x_r   <= cur_x_r || (s_vld && s_exc);
      oth_any_r <= oth_any_r || s_other;
      oth_x_r   <= oth_x_r || (s_other && s_exc);
      oth_old_r <= oth_old_r || (s_other && s_not_younger);
    end
  end

  // Checks
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !ram_wr_en)
    else $error("holder RAM written while idle");

  a_decide_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DECIDE && out_free) |=> (out_rsp.valid && state_r == S_IDLE))
    else $error("decision did not load the response register");

  a_grant_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_rsp.valid && out_rsp.status == twd_pkg::STAT_GRANTED)
      |-> out_rsp.group_mode != twd_pkg::MODE_NONE)
    else $error("grant reported with no group mode");

  a_upgrade_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_rsp.valid && out_rsp.status == twd_pkg::STAT_UPGRADED)
      |-> out_rsp.group_mode == twd_pkg::MODE_X)
    else $error("upgrade reported without exclusive mode");

endmodule

/* tb/sv/tb_table_lock_wait_die.sv */
module tb_table_lock_wait_die;
  import twd_pkg::*;

  localparam int NUM_TABLES  = 64;
  localparam int NUM_HOLDERS = 16;
  localparam int NUM_TXN_BIT = 16;
  localparam int RAND_WORDS  = 514;
  localparam int POOL_SIZE   = 24;
  localparam int HOT_TABLES  = 4;
  localparam int DRAIN_WAIT  = 40;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_AFTER  = 120;
  localparam int HOLD_LEN    = 400;

  // Unlock alias: any code above unlock also releases
  localparam logic [CMD_W-1:0] CMD_UNLOCK_ALT = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [TABLE_W-1:0] table_id;
    logic [TXN_W-1:0]   txn_id;
    logic [STAMP_W-1:0] start_stamp;
    logic               txn_shrinking;
  } lock_req_t;

  typedef struct packed {
    status_t status;
    mode_t   mode;
  } lock_rsp_t;

  typedef struct {
    lock_req_t req;
    int        reps;   // repeats with txn and stamp stepped by one
    bit        typed;  // expected word given below instead of predicted
    lock_rsp_t want;
  } dir_row_t;

  typedef enum {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_PULSE} rdy_style_t;

  logic clk = 1'b0;
  logic rst_n;

  twd_req_if in_req();
  twd_rsp_if out_rsp();

  table_lock_wait_die #(
    .TABLES  (NUM_TABLES),
    .HOLDERS (NUM_HOLDERS),
    .TXN_BITS(NUM_TXN_BIT)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_req),
    .out_rsp(out_rsp)
  );

  always #5 clk = ~clk;

  // Directed sequence: one table walked through every decision but full, a
  // holder row filled to the brim, and the extreme table and transaction ids
  dir_row_t dir_tab [21] = '{
    '{'{CMD_LOCK_S, 6'd1, 16'd10, 32'd100, 1'b0}, 1, 1'b1, '{STAT_GRANTED, MODE_S}},
    '{'{CMD_LOCK_S, 6'd1, 16'd10, 32'd100, 1'b0}, 1, 1'b1, '{STAT_HELD, MODE_S}},
    '{'{CMD_LOCK_S, 6'd1, 16'd11, 32'd50, 1'b0}, 1, 1'b1, '{STAT_GRANTED, MODE_S}},
    '{'{CMD_LOCK_X, 6'd1, 16'd10, 32'd100, 1'b0}, 1, 1'b1, '{STAT_ABORT_DIE, MODE_S}},
    '{'{CMD_LOCK_X, 6'd1, 16'd12, 32'd10, 1'b0}, 1, 1'b1, '{STAT_WAIT, MODE_S}},
    '{'{CMD_LOCK_X, 6'd1, 16'd12, 32'd50, 1'b0}, 1, 1'b1, '{STAT_ABORT_DIE, MODE_S}},
    '{'{CMD_UNLOCK, 6'd1, 16'd11, 32'd50, 1'b0}, 1, 1'b1, '{STAT_RELEASED, MODE_S}},
    '{'{CMD_LOCK_X, 6'd1, 16'd10, 32'd100, 1'b0}, 1, 1'b1, '{STAT_UPGRADED, MODE_X}},
    '{'{CMD_LOCK_X, 6'd1, 16'd10, 32'd100, 1'b0}, 1, 1'b1, '{STAT_HELD, MODE_X}},
    '{'{CMD_LOCK_S, 6'd1, 16'd10, 32'd100, 1'b0}, 1, 1'b1, '{STAT_HELD, MODE_X}},
    '{'{CMD_LOCK_S, 6'd1, 16'd13, 32'd0, 1'b1}, 1, 1'b1, '{STAT_ABORT_SHRINK, MODE_X}},
    '{'{CMD_LOCK_S, 6'd1, 16'd13, 32'd0, 1'b0}, 1, 1'b1, '{STAT_WAIT, MODE_X}},
    '{'{CMD_LOCK_S, 6'd1, 16'd14, 32'hFFFF_FFFF, 1'b0}, 1, 1'b1, '{STAT_ABORT_DIE, MODE_X}},
    '{'{CMD_UNLOCK_ALT, 6'd1, 16'd10, 32'd0, 1'b1}, 1, 1'b1, '{STAT_RELEASED, MODE_NONE}},
    '{'{CMD_UNLOCK, 6'd1, 16'd10, 32'd0, 1'b0}, 1, 1'b1, '{STAT_RELEASED, MODE_NONE}},
    '{'{CMD_LOCK_S, 6'd0, 16'd0, 32'd0, 1'b0}, NUM_HOLDERS, 1'b0, '{STAT_GRANTED, MODE_S}},
    '{'{CMD_LOCK_S, 6'd0, 16'hFFFF, 32'hFFFF_FFFF, 1'b0}, 1, 1'b1, '{STAT_FULL, MODE_S}},
    '{'{CMD_LOCK_X, 6'd63, 16'hFFFF, 32'hFFFF_FFFF, 1'b0}, 1, 1'b1, '{STAT_GRANTED, MODE_X}},
    '{'{CMD_LOCK_S, 6'd63, 16'd0, 32'd0, 1'b0}, 1, 1'b1, '{STAT_WAIT, MODE_X}},
    '{'{CMD_UNLOCK, 6'd63, 16'hFFFF, 32'd0, 1'b0}, 1, 1'b1, '{STAT_RELEASED, MODE_NONE}},
    '{'{CMD_LOCK_X, 6'd42, 16'h5AA5, 32'hA5A5_5A5A, 1'b1}, 1, 1'b1,
      '{STAT_ABORT_SHRINK, MODE_NONE}}
  };

  // Lock table image kept by the testbench
  bit                 slot_vld   [NUM_TABLES][NUM_HOLDERS];
  logic [TXN_W-1:0]   slot_txn   [NUM_TABLES][NUM_HOLDERS];
  logic [STAMP_W-1:0] slot_stamp [NUM_TABLES][NUM_HOLDERS];
  bit                 slot_excl  [NUM_TABLES][NUM_HOLDERS];
  mode_t              grp_mode   [NUM_TABLES];

  lock_rsp_t expected_rsp_q [$];
  int        err_cnt   = 0;
  int        cycle_cnt = 0;
  int        burst_left = 0;

  // Receiver state
  int         req_taken  = 0;
  int         hold_left  = 0;
  bit         hold_done  = 1'b0;
  int         style_left = 0;
  rdy_style_t rdy_style  = RDY_ALWAYS;

  task automatic report_mismatch(input string what);
    err_cnt++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Apply one request to the table image and return the word it yields
  function automatic lock_rsp_t lock_decide(input lock_req_t r);
    int        t;
    int        own;
    int        free_slot;
    logic      want_x;
    logic      others;
    logic      older;
    mode_t     m;
    lock_rsp_t res;
    t         = int'(r.table_id) % NUM_TABLES;
    own       = -1;
    free_slot = -1;
    others    = 1'b0;
    older     = 1'b1;
    want_x    = (r.command == CMD_LOCK_X);
    for (int i = 0; i < NUM_HOLDERS; i++) begin
      if (!slot_vld[t][i]) begin
        if (free_slot < 0) free_slot = i;
      end else if (slot_txn[t][i] == r.txn_id) begin
        if (own < 0) own = i;
      end else begin
        others = 1'b1;
        // wait-die: must be strictly older than every other holder
        if (!(r.start_stamp < slot_stamp[t][i])) older = 1'b0;
      end
    end

    if (r.command >= CMD_UNLOCK) begin
      m = MODE_NONE;
      for (int i = 0; i < NUM_HOLDERS; i++)
        if (slot_vld[t][i] && slot_txn[t][i] == r.txn_id) slot_vld[t][i] = 1'b0;
      for (int i = 0; i < NUM_HOLDERS; i++) begin
        if (slot_vld[t][i]) begin
          if (slot_excl[t][i]) m = MODE_X;
          else if (m != MODE_X) m = MODE_S;
        end
      end
      grp_mode[t] = m;
      res.status  = STAT_RELEASED;
    end else if (r.txn_shrinking) begin
      res.status = STAT_ABORT_SHRINK;
    end else if (own >= 0) begin
      if (!want_x || slot_excl[t][own]) begin
        res.status = STAT_HELD;
      end else if (!others) begin
        slot_excl[t][own] = 1'b1;
        grp_mode[t]       = MODE_X;
        res.status        = STAT_UPGRADED;
      end else begin
        res.status = STAT_ABORT_DIE;
      end
    end else if ((want_x && grp_mode[t] != MODE_NONE) || (!want_x && grp_mode[t] == MODE_X)) begin
      res.status = older ? STAT_WAIT : STAT_ABORT_DIE;
    end else if (free_slot < 0) begin
      res.status = STAT_FULL;
    end else begin
      slot_vld[t][free_slot]   = 1'b1;
      slot_txn[t][free_slot]   = r.txn_id;
      slot_stamp[t][free_slot] = r.start_stamp;
      slot_excl[t][free_slot]  = want_x;
      grp_mode[t]              = want_x ? MODE_X : MODE_S;
      res.status               = STAT_GRANTED;
    end
    res.mode = grp_mode[t];
    return res;
  endfunction

  // Offer one request word in bursts with random gaps; predict on acceptance
  task automatic offer_word(input lock_req_t r, output lock_rsp_t res);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
      if (gap != 0) begin
        in_req.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_req.valid         <= 1'b1;
    in_req.command       <= r.command;
    in_req.table_id      <= r.table_id;
    in_req.txn_id        <= r.txn_id;
    in_req.start_stamp   <= r.start_stamp;
    in_req.txn_shrinking <= r.txn_shrinking;
    do @(posedge clk); while (!in_req.ready);
    res = lock_decide(r);
  endtask

  // Main stimulus
  initial begin
    lock_req_t          r;
    lock_rsp_t          e;
    logic [TXN_W-1:0]   pool_txn   [POOL_SIZE];
    logic [STAMP_W-1:0] pool_stamp [POOL_SIZE];
    logic [TABLE_W-1:0] hot_tbl    [HOT_TABLES];
    logic [63:0]        noise;
    int                 unlock_pct;
    int                 pick;
    int                 roll;

    rst_n                 <= 1'b0;
    in_req.valid          <= 1'b0;
    in_req.command        <= CMD_LOCK_S;
    in_req.table_id       <= '0;
    in_req.txn_id         <= '0;
    in_req.start_stamp    <= '0;
    in_req.txn_shrinking  <= 1'b0;

    for (int t = 0; t < NUM_TABLES; t++) begin
      grp_mode[t] = MODE_NONE;
      for (int i = 0; i < NUM_HOLDERS; i++) slot_vld[t][i] = 1'b0;
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part
    foreach (dir_tab[i]) begin
      for (int n = 0; n < dir_tab[i].reps; n++) begin
        r             = dir_tab[i].req;
        r.txn_id      = r.txn_id + TXN_W'(n);
        r.start_stamp = r.start_stamp + STAMP_W'(n);
        offer_word(r, e);
        if (dir_tab[i].typed) e = dir_tab[i].want;
        expected_rsp_q.push_back(e);
      end
    end

    // Transaction pool with some shared start stamps, and a few hot tables
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_txn[i]   = TXN_W'($urandom);
      pool_stamp[i] = (i > 0 && $urandom_range(0, 4) == 0) ? pool_stamp[i-1] : $urandom;
    end
    foreach (hot_tbl[i]) hot_tbl[i] = TABLE_W'($urandom_range(1, NUM_TABLES - 2));

    // Random part: mostly pool transactions on hot tables, some noise
    unlock_pct = 25;
    for (int k = 0; k < RAND_WORDS; k++) begin
      if (k % 60 == 0) begin
        case ($urandom_range(0, 2))
          0:       unlock_pct = 6;
          1:       unlock_pct = 25;
          default: unlock_pct = 45;
        endcase
      end
      if ($urandom_range(0, 99) < 6) begin
        noise = {$urandom, $urandom};
        r     = noise[$bits(lock_req_t)-1:0];
      end else begin
        pick            = $urandom_range(0, POOL_SIZE - 1);
        r.txn_id        = pool_txn[pick];
        r.start_stamp   = pool_stamp[pick];
        r.table_id      = ($urandom_range(0, 9) == 0) ? TABLE_W'($urandom)
                                                      : hot_tbl[$urandom_range(0, HOT_TABLES - 1)];
        r.txn_shrinking = ($urandom_range(0, 15) == 0);
        roll            = $urandom_range(0, 99);
        if (roll < unlock_pct)
          r.command = ($urandom_range(0, 7) == 0) ? CMD_UNLOCK_ALT : CMD_UNLOCK;
        else
          r.command = roll[0] ? CMD_LOCK_X : CMD_LOCK_S;
      end
      offer_word(r, e);
      expected_rsp_q.push_back(e);
    end

    // Drain
    in_req.valid <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (err_cnt == 0)
      $display("tb_table_lock_wait_die: done, clean");
    else
      $display("tb_table_lock_wait_die: done, errors");
    $finish;
  end

  // Receiver: changing stall styles plus one long hold-off to back up the block
  always @(posedge clk) begin
    if (in_req.valid && in_req.ready) req_taken <= req_taken + 1;
    if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      out_rsp.ready <= 1'b0;
    end else if (!hold_done && req_taken >= HOLD_AFTER) begin
      hold_done     <= 1'b1;
      hold_left     <= HOLD_LEN;
      out_rsp.ready <= 1'b0;
    end else begin
      if (style_left == 0) begin
        style_left <= $urandom_range(8, 120);
        rdy_style  <= rdy_style_t'($urandom_range(0, 3));
      end else begin
        style_left <= style_left - 1;
      end
      case (rdy_style)
        RDY_ALWAYS: out_rsp.ready <= 1'b1;
        RDY_COIN:   out_rsp.ready <= 1'($urandom_range(0, 1));
        RDY_SPARSE: out_rsp.ready <= ($urandom_range(0, 5) == 0);
        default:    out_rsp.ready <= (cycle_cnt[2:0] < 3'd3);
      endcase
    end
  end

  // Response check against the oldest expected word
  always @(posedge clk) begin
    lock_rsp_t e;
    if (rst_n && out_rsp.valid && out_rsp.ready) begin
      if (expected_rsp_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word status %0d mode %0d",
                                  out_rsp.status, out_rsp.group_mode));
      end else begin
        e = expected_rsp_q.pop_front();
        if (out_rsp.status !== e.status)
          report_mismatch($sformatf("status %0d, expected %0d", out_rsp.status, e.status));
        if (out_rsp.group_mode !== e.mode)
          report_mismatch($sformatf("group_mode %0d, expected %0d",
                                    out_rsp.group_mode, e.mode));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb_table_lock_wait_die: done, errors");
      $finish;
    end
  end

endmodule
